[src/mstod_pkg.sv]
package mstod_pkg;

    // field widths
    localparam int SAMPLE_W  = 32;
    localparam int DAY_BITS  = 16;
    localparam int MICRO_W   = 20;
    localparam int MILLI_W   = 10;
    localparam int SEC_W     = 6;
    localparam int MIN_W     = 6;
    localparam int HOUR_W    = 5;
    localparam int DAY_OUT_W = 16;
    localparam int TH_W      = 21;
    localparam int TM_W      = 27;
    localparam int TS_W      = 33;

    // internal widths
    localparam int TOT_W    = 33;
    localparam int QS_W     = 13;
    localparam int SECSUM_W = 13;
    localparam int QM_W     = 7;
    localparam int Y_W      = 8;

    // time constants
    localparam int US_PER_S     = 1000000;
    localparam int US_PER_MS    = 1000;
    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;

    // one timer wrap (2^32 us) is 1 h 11 min 34 s 967296 us
    localparam int WRAP_US_PART = 967296;
    localparam int WRAP_S_PART  = 34;
    localparam int WRAP_M_PART  = 11;
    localparam int WRAP_H_PART  = 1;

    // reciprocals for division by constants, exact over the operand ranges used
    localparam int RECIP_US_W     = 31;
    localparam logic [RECIP_US_W-1:0] RECIP_US = 31'd1125899907;
    localparam int RECIP_US_SHIFT = 50;
    localparam int RECIP_60_W     = 13;
    localparam logic [RECIP_60_W-1:0] RECIP_60 = 13'd4370;
    localparam int RECIP_60_SHIFT = 18;
    localparam int RECIP_MS_W     = 21;
    localparam logic [RECIP_MS_W-1:0] RECIP_MS = 21'd1073742;
    localparam int RECIP_MS_SHIFT = 30;

    localparam int STAGES = 10;

    typedef struct packed {
        logic [MICRO_W-1:0]  micro;
        logic [SEC_W-1:0]    second;
        logic [MIN_W-1:0]    minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_BITS-1:0] day;
    } t_off;

    typedef struct packed {
        logic [MICRO_W-1:0]  micro;
        logic [MILLI_W-1:0]  milli;
        logic [SEC_W-1:0]    second;
        logic [MIN_W-1:0]    minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_BITS-1:0] day;
    } t_tod;

    typedef logic [TOT_W-1:0] t_tot;

endpackage

[src/mstod_if.sv]
interface mstod_sample_if;
    import mstod_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] micro_sample;

    modport source (output valid, output micro_sample, input ready);
    modport sink (input valid, input micro_sample, output ready);
endinterface

interface mstod_result_if;
    import mstod_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MICRO_W-1:0]   micro_in_second;
    logic [MILLI_W-1:0]   milli_in_second;
    logic [SEC_W-1:0]     second_of_minute;
    logic [MIN_W-1:0]     minute_of_hour;
    logic [HOUR_W-1:0]    hour_of_day;
    logic [DAY_OUT_W-1:0] day_count;
    logic [TH_W-1:0]      total_hours;
    logic [TM_W-1:0]      total_minutes;
    logic [TS_W-1:0]      total_seconds;

    modport source (
        output valid, output micro_in_second, output milli_in_second,
        output second_of_minute, output minute_of_hour, output hour_of_day,
        output day_count, output total_hours, output total_minutes,
        output total_seconds, input ready
    );
    modport sink (
        input valid, input micro_in_second, input milli_in_second,
        input second_of_minute, input minute_of_hour, input hour_of_day,
        input day_count, input total_hours, input total_minutes,
        input total_seconds, output ready
    );
endinterface

[src/microsecond_timer_time_of_day.sv]
// Time of day from a free-running 32-bit microsecond timer. Each sample transfer
// yields one result transfer with the elapsed time split into microsecond,
// millisecond, second, minute, hour and day, plus running totals of hours,
// minutes and seconds. A sample smaller than the one before counts as one
// timer wrap and adds 2^32 us to the stored offset. One sample is taken every
// cycle while ready is high; a result is offered once its sample has passed the ten
// register stages of constant-reciprocal multiplies and carry steps, the first
// of which loads at the sample transfer itself. Ready drops only while the
// output register holds a result that has not been taken.
module microsecond_timer_time_of_day (
    input logic                 i_clk,
    input logic                 i_rst_n,
    mstod_sample_if.sink        i_sample,
    mstod_result_if.source      o_time
);
    import mstod_pkg::*;

    localparam int PUS_W = SAMPLE_W + RECIP_US_W;
    localparam int P60_W = SECSUM_W + RECIP_60_W;
    localparam int PMS_W = MICRO_W + RECIP_MS_W;

    function automatic t_off wrap_add(input t_off o);
        t_off               r;
        logic [MICRO_W:0]   u;
        logic [SEC_W:0]     s;
        logic [MIN_W:0]     m;
        logic [HOUR_W:0]    h;
        logic               cu;
        logic               cs;
        logic               cm;
        logic               ch;
        u  = {1'b0, o.micro} + (MICRO_W+1)'(WRAP_US_PART);
        cu = (u >= (MICRO_W+1)'(US_PER_S));
        r.micro = cu ? MICRO_W'(u - (MICRO_W+1)'(US_PER_S)) : u[MICRO_W-1:0];
        s  = {1'b0, o.second} + (SEC_W+1)'(WRAP_S_PART) + (SEC_W+1)'(cu);
        cs = (s >= (SEC_W+1)'(SEC_PER_MIN));
        r.second = cs ? SEC_W'(s - (SEC_W+1)'(SEC_PER_MIN)) : s[SEC_W-1:0];
        m  = {1'b0, o.minute} + (MIN_W+1)'(WRAP_M_PART) + (MIN_W+1)'(cs);
        cm = (m >= (MIN_W+1)'(MIN_PER_HOUR));
        r.minute = cm ? MIN_W'(m - (MIN_W+1)'(MIN_PER_HOUR)) : m[MIN_W-1:0];
        h  = {1'b0, o.hour} + (HOUR_W+1)'(WRAP_H_PART) + (HOUR_W+1)'(cm);
        ch = (h >= (HOUR_W+1)'(HOUR_PER_DAY));
        r.hour = ch ? HOUR_W'(h - (HOUR_W+1)'(HOUR_PER_DAY)) : h[HOUR_W-1:0];
        r.day  = o.day + DAY_BITS'(ch);
        return r;
    endfunction

    logic                  w_adv;
    logic                  w_accept;
    logic [STAGES-1:0]     r_vld;
    logic [SAMPLE_W-1:0]   r_last_sample;
    t_off                  r_off;
    t_off                  n_off;

    // stage registers
    logic [SAMPLE_W-1:0]   r1_sample;
    logic                  r1_wrap;
    logic [SAMPLE_W-1:0]   r2_sample;
    logic [QS_W-1:0]       r2_q;
    t_off                  r2_off;
    logic [MICRO_W-1:0]    r3_rem;
    logic [QS_W-1:0]       r3_q;
    t_off                  r3_off;
    logic [MICRO_W-1:0]    r4_micro;
    logic [SECSUM_W-1:0]   r4_secsum;
    t_off                  r4_off;
    logic [MICRO_W-1:0]    r5_micro;
    logic [SECSUM_W-1:0]   r5_secsum;
    logic [QM_W-1:0]       r5_qm;
    t_off                  r5_off;
    logic [MICRO_W-1:0]    r6_micro;
    logic [SEC_W-1:0]      r6_sec;
    logic [Y_W-1:0]        r6_y;
    t_off                  r6_off;
    t_tod                  r7_tod;
    t_tod                  r8_tod;
    t_tot                  r8_th;
    t_tod                  r9_tod;
    t_tot                  r9_th;
    t_tot                  r9_tm;
    t_tod                  r10_tod;
    t_tot                  r10_th;
    t_tot                  r10_tm;
    t_tot                  r10_ts;

    // combinational per stage
    logic [PUS_W-1:0]      prod_us;
    logic [SAMPLE_W-1:0]   rem_full;
    logic [MICRO_W:0]      usum;
    logic                  ucarry;
    logic [MICRO_W-1:0]    micro_norm;
    logic [P60_W-1:0]      prod_60;
    logic [SECSUM_W-1:0]   sec_full;
    logic [Y_W-1:0]        min_norm;
    logic [1:0]            qh;
    logic [HOUR_W-1:0]     hsum;
    logic                  dcarry;
    logic [PMS_W-1:0]      prod_ms;
    t_tod                  tod7;

    assign w_adv    = !r_vld[STAGES-1] || o_time.ready;
    assign w_accept = i_sample.valid && w_adv;
    assign i_sample.ready = w_adv;

    assign n_off = r1_wrap ? wrap_add(r_off) : r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_last_sample <= '0;
            r_off         <= '0;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[STAGES-2:0], i_sample.valid};
                if (r_vld[0]) begin
                    r_off <= n_off;
                end
            end
            if (w_accept) begin
                r_last_sample <= i_sample.micro_sample;
            end
        end
    end

    // stage 2: seconds in the sample by reciprocal multiply
    assign prod_us = PUS_W'(r1_sample) * PUS_W'(RECIP_US);

    // stage 3: microsecond remainder
    assign rem_full = r2_sample - SAMPLE_W'(r2_q) * SAMPLE_W'(US_PER_S);

    // stage 4: add offset microseconds, carry into seconds
    assign usum       = (MICRO_W+1)'(r3_off.micro) + (MICRO_W+1)'(r3_rem);
    assign ucarry     = (usum >= (MICRO_W+1)'(US_PER_S));
    assign micro_norm = ucarry ? MICRO_W'(usum - (MICRO_W+1)'(US_PER_S))
                               : usum[MICRO_W-1:0];

    // stage 5: whole minutes in the second sum
    assign prod_60 = P60_W'(r4_secsum) * P60_W'(RECIP_60);

    // stage 6: second of minute
    assign sec_full = r5_secsum - SECSUM_W'(r5_qm) * SECSUM_W'(SEC_PER_MIN);

    // stage 7: minute and hour carries, milliseconds
    always_comb begin
        if (r6_y >= Y_W'(2 * MIN_PER_HOUR)) begin
            qh       = 2'd2;
            min_norm = r6_y - Y_W'(2 * MIN_PER_HOUR);
        end else if (r6_y >= Y_W'(MIN_PER_HOUR)) begin
            qh       = 2'd1;
            min_norm = r6_y - Y_W'(MIN_PER_HOUR);
        end else begin
            qh       = 2'd0;
            min_norm = r6_y;
        end
        hsum   = r6_off.hour + HOUR_W'(qh);
        dcarry = (hsum >= HOUR_W'(HOUR_PER_DAY));
        prod_ms = PMS_W'(r6_micro) * PMS_W'(RECIP_MS);
        tod7.micro  = r6_micro;
        tod7.milli  = prod_ms[RECIP_MS_SHIFT +: MILLI_W];
        tod7.second = r6_sec;
        tod7.minute = min_norm[MIN_W-1:0];
        tod7.hour   = dcarry ? HOUR_W'(hsum - HOUR_W'(HOUR_PER_DAY)) : hsum;
        tod7.day    = r6_off.day + DAY_BITS'(dcarry);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sample <= i_sample.micro_sample;
            r1_wrap   <= (i_sample.micro_sample < r_last_sample);

            r2_sample <= r1_sample;
            r2_q      <= prod_us[RECIP_US_SHIFT +: QS_W];
            r2_off    <= n_off;

            r3_rem    <= rem_full[MICRO_W-1:0];
            r3_q      <= r2_q;
            r3_off    <= r2_off;

            r4_micro  <= micro_norm;
            r4_secsum <= SECSUM_W'(r3_q) + SECSUM_W'(ucarry) + SECSUM_W'(r3_off.second);
            r4_off    <= r3_off;

            r5_micro  <= r4_micro;
            r5_secsum <= r4_secsum;
            r5_qm     <= prod_60[RECIP_60_SHIFT +: QM_W];
            r5_off    <= r4_off;

            r6_micro  <= r5_micro;
            r6_sec    <= sec_full[SEC_W-1:0];
            r6_y      <= Y_W'(r5_qm) + Y_W'(r5_off.minute);
            r6_off    <= r5_off;

            r7_tod    <= tod7;

            r8_tod    <= r7_tod;
            r8_th     <= t_tot'(r7_tod.day) * t_tot'(HOUR_PER_DAY) + t_tot'(r7_tod.hour);

            r9_tod    <= r8_tod;
            r9_th     <= r8_th;
            r9_tm     <= r8_th * t_tot'(MIN_PER_HOUR) + t_tot'(r8_tod.minute);

            r10_tod   <= r9_tod;
            r10_th    <= r9_th;
            r10_tm    <= r9_tm;
            r10_ts    <= r9_tm * t_tot'(SEC_PER_MIN) + t_tot'(r9_tod.second);
        end
    end

    assign o_time.valid            = r_vld[STAGES-1];
    assign o_time.micro_in_second  = r10_tod.micro;
    assign o_time.milli_in_second  = r10_tod.milli;
    assign o_time.second_of_minute = r10_tod.second;
    assign o_time.minute_of_hour   = r10_tod.minute;
    assign o_time.hour_of_day      = r10_tod.hour;
    assign o_time.day_count        = DAY_OUT_W'(r10_tod.day);
    assign o_time.total_hours      = r10_th[TH_W-1:0];
    assign o_time.total_minutes    = r10_tm[TM_W-1:0];
    assign o_time.total_seconds    = r10_ts[TS_W-1:0];

endmodule

[src/mstod_checker.sv]
module mstod_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [mstod_pkg::MICRO_W-1:0]   i_micro,
    input logic [mstod_pkg::MILLI_W-1:0]   i_milli,
    input logic [mstod_pkg::SEC_W-1:0]     i_sec,
    input logic [mstod_pkg::MIN_W-1:0]     i_min,
    input logic [mstod_pkg::HOUR_W-1:0]    i_hour,
    input logic [mstod_pkg::DAY_OUT_W-1:0] i_day,
    input logic [mstod_pkg::TH_W-1:0]      i_total_hours,
    input logic [mstod_pkg::TM_W-1:0]      i_total_minutes,
    input logic [mstod_pkg::TS_W-1:0]      i_total_seconds
);
    import mstod_pkg::*;

    logic [DAY_OUT_W-1:0] th_lo;
    logic [TH_W-1:0]      tm_lo;
    logic [TM_W-1:0]      ts_lo;
    logic                 fields_ok;
    logic                 totals_ok;

    // totals agree with the parts modulo the narrower field
    assign th_lo = DAY_OUT_W'(i_day * DAY_OUT_W'(HOUR_PER_DAY) + DAY_OUT_W'(i_hour));
    assign tm_lo = TH_W'(i_total_hours * TH_W'(MIN_PER_HOUR) + TH_W'(i_min));
    assign ts_lo = TM_W'(i_total_minutes * TM_W'(SEC_PER_MIN) + TM_W'(i_sec));

    assign totals_ok = (i_total_hours[DAY_OUT_W-1:0] == th_lo)
                    && (i_total_minutes[TH_W-1:0] == tm_lo)
                    && (i_total_seconds[TM_W-1:0] == ts_lo);

    assign fields_ok = (32'(i_micro) < 32'(US_PER_S))
                    && (32'(i_milli) == 32'(i_micro) / 32'(US_PER_MS))
                    && (i_sec < SEC_W'(SEC_PER_MIN))
                    && (i_min < MIN_W'(MIN_PER_HOUR))
                    && (i_hour < HOUR_W'(HOUR_PER_DAY));

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped before transfer");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_micro, i_milli, i_sec, i_min,
            i_hour, i_day, i_total_hours, i_total_minutes, i_total_seconds}))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_fields_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> fields_ok)
        else $error("time fields not normalized");

    a_totals_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> totals_ok)
        else $error("running totals disagree with time fields");

endmodule

bind microsecond_timer_time_of_day mstod_checker u_mstod_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_time.valid),
    .i_out_ready     (o_time.ready),
    .i_micro         (o_time.micro_in_second),
    .i_milli         (o_time.milli_in_second),
    .i_sec           (o_time.second_of_minute),
    .i_min           (o_time.minute_of_hour),
    .i_hour          (o_time.hour_of_day),
    .i_day           (o_time.day_count),
    .i_total_hours   (o_time.total_hours),
    .i_total_minutes (o_time.total_minutes),
    .i_total_seconds (o_time.total_seconds)
);

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mstod_pkg::*;

    localparam int RESET_CYCLES    = 6;
    localparam int PIPE_LATENCY    = 10;
    localparam int DRAIN_CYCLES    = 4 * PIPE_LATENCY;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_READINGS = 900;
    localparam int TAIL_READINGS   = 150;
    // mostly descending readings; each step downward is a timer wrap
    localparam int ROLLOVER_READINGS = 80;
    localparam int QUEUE_LEAD      = 256;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [63:0] US_SEC  = 64'(US_PER_S);
    localparam logic [63:0] US_MIN  = US_SEC * SEC_PER_MIN;
    localparam logic [63:0] US_HOUR = US_MIN * MIN_PER_HOUR;
    localparam logic [63:0] US_DAY  = US_HOUR * HOUR_PER_DAY;
    localparam logic [63:0] TIMER_WRAP_US = 64'h1_0000_0000;

    typedef struct packed {
        logic [MICRO_W-1:0]   micro;
        logic [MILLI_W-1:0]   milli;
        logic [SEC_W-1:0]     second;
        logic [MIN_W-1:0]     minute;
        logic [HOUR_W-1:0]    hour;
        logic [DAY_OUT_W-1:0] day;
        logic [TH_W-1:0]      hours_total;
        logic [TM_W-1:0]      minutes_total;
        logic [TS_W-1:0]      seconds_total;
    } t_elapsed;

    logic i_clk;
    logic i_rst_n;

    mstod_sample_if sample_if();
    mstod_result_if time_if();

    microsecond_timer_time_of_day DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(sample_if),
        .o_time  (time_if)
    );

    logic [31:0] pending_q [$];
    t_elapsed    elapsed_q [$];

    // predictor state
    logic [31:0] prev_reading;
    t_off        wrap_offset;
    logic [DAY_OUT_W-1:0] last_day_seen;

    logic steady;
    logic hold_go;
    logic hold_done;

    int queued_count;
    int accepted_count;
    int checked_count;
    int wrap_count;
    int rollover_count;
    int miss_count;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int rx_phase;
    int rx_period;
    int rx_busy;
    int hold_left;

    logic [31:0] edge_readings [$] = '{
        32'd0, 32'd999_999, 32'd1_000_000, 32'd59_999_999, 32'd60_000_000,
        32'd3_599_999_999, 32'd3_600_000_000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFE, 32'd0, 32'd0, 32'd1, 32'd0, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd86_399_999,
        32'd999, 32'd1000
    };

    // stored offset plus extra microseconds, normalized, days kept to DAY_BITS
    function automatic t_off advance_offset(input t_off base, input logic [63:0] extra);
        t_off        r;
        logic [63:0] span;
        logic [63:0] days;
        span = base.hour * US_HOUR + base.minute * US_MIN + base.second * US_SEC
             + base.micro + extra;
        days = base.day + span / US_DAY;
        span = span % US_DAY;
        r.day    = days[DAY_BITS-1:0];
        r.hour   = HOUR_W'(span / US_HOUR);
        span     = span % US_HOUR;
        r.minute = MIN_W'(span / US_MIN);
        span     = span % US_MIN;
        r.second = SEC_W'(span / US_SEC);
        r.micro  = MICRO_W'(span % US_SEC);
        return r;
    endfunction

    function automatic t_elapsed elapsed_at(input t_off base, input logic [31:0] reading);
        t_off        t;
        t_elapsed    e;
        logic [63:0] hrs;
        logic [63:0] mins;
        logic [63:0] secs;
        t    = advance_offset(base, {32'd0, reading});
        hrs  = t.day * HOUR_PER_DAY + t.hour;
        mins = hrs * MIN_PER_HOUR + t.minute;
        secs = mins * SEC_PER_MIN + t.second;
        e.micro         = t.micro;
        e.milli         = MILLI_W'(t.micro / US_PER_MS);
        e.second        = t.second;
        e.minute        = t.minute;
        e.hour          = t.hour;
        e.day           = t.day;
        e.hours_total   = hrs[TH_W-1:0];
        e.minutes_total = mins[TM_W-1:0];
        e.seconds_total = secs[TS_W-1:0];
        return e;
    endfunction

    task automatic take_reading(input logic [31:0] reading);
        t_elapsed e;
        if (reading < prev_reading) begin
            wrap_offset = advance_offset(wrap_offset, TIMER_WRAP_US);
            wrap_count++;
        end
        prev_reading = reading;
        e = elapsed_at(wrap_offset, reading);
        if (e.day < last_day_seen)
            rollover_count++;
        last_day_seen = e.day;
        elapsed_q.push_back(e);
    endtask

    task automatic show_elapsed(input string tag, input t_elapsed e);
        $display("  %s: us=%0d ms=%0d s=%0d m=%0d h=%0d d=%0d th=%0d tm=%0d ts=%0d",
                 tag, e.micro, e.milli, e.second, e.minute, e.hour, e.day,
                 e.hours_total, e.minutes_total, e.seconds_total);
    endtask

    task automatic queue_reading(input logic [31:0] reading);
        while (pending_q.size() >= QUEUE_LEAD)
            @(posedge i_clk);
        pending_q.push_back(reading);
        queued_count++;
    endtask

    function automatic logic [31:0] next_reading(input logic [31:0] cur);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return cur + $urandom_range(0, 5_000_000);
        else if (pick < 85)
            return cur + $urandom;
        else if (pick < 92)
            return $urandom;
        else if (pick < 97) begin
            case ($urandom_range(0, 3))
                0: return 32'd0;
                1: return 32'hFFFF_FFFF;
                2: return 32'd999_999;
                default: return 32'd1_000_000;
            endcase
        end
        return cur;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // sample driver: bursts of transfers with random gaps, no gaps in steady mode
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_if.valid        <= 1'b0;
            sample_if.micro_sample <= '0;
        end else if (!sample_if.valid || sample_if.ready) begin
            if (gap_left > 0 && !steady) begin
                sample_if.valid <= 1'b0;
                gap_left--;
            end else if (pending_q.size() > 0) begin
                sample_if.valid        <= 1'b1;
                sample_if.micro_sample <= pending_q.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                sample_if.valid <= 1'b0;
            end
        end
    end

    // result side: stall pattern, one long hold-off, always ready in steady mode
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            time_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            time_if.ready <= 1'b0;
            hold_left--;
        end else if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            time_if.ready <= 1'b0;
        end else if (steady) begin
            time_if.ready <= 1'b1;
        end else begin
            if (rx_phase == 0) begin
                rx_period = $urandom_range(2, 12);
                rx_busy   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, rx_period - 1);
            end
            time_if.ready <= (rx_phase >= rx_busy);
            rx_phase = (rx_phase + 1) % rx_period;
        end
    end

    // monitor: check results before predicting, so a same-edge pair stays ordered
    always @(posedge i_clk) begin
        t_elapsed got;
        t_elapsed want;
        if (i_rst_n) begin
            idle_cycles++;
            if (time_if.valid && time_if.ready) begin
                idle_cycles = 0;
                got = '{micro: time_if.micro_in_second, milli: time_if.milli_in_second,
                        second: time_if.second_of_minute, minute: time_if.minute_of_hour,
                        hour: time_if.hour_of_day, day: time_if.day_count,
                        hours_total: time_if.total_hours,
                        minutes_total: time_if.total_minutes,
                        seconds_total: time_if.total_seconds};
                if (elapsed_q.size() == 0) begin
                    miss_count++;
                    if (miss_count <= REPORT_LIMIT) begin
                        $display("result %0d arrived with nothing expected", checked_count);
                        show_elapsed("got", got);
                    end
                end else begin
                    want = elapsed_q.pop_front();
                    if (got !== want) begin
                        miss_count++;
                        if (miss_count <= REPORT_LIMIT) begin
                            $display("mismatch on result %0d", checked_count);
                            show_elapsed("exp", want);
                            show_elapsed("got", got);
                        end
                    end
                end
                checked_count++;
            end
            if (sample_if.valid && sample_if.ready) begin
                idle_cycles = 0;
                accepted_count++;
                take_reading(sample_if.micro_sample);
            end
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("no transfer for %0d cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] reading;
        sample_if.valid        = 1'b0;
        sample_if.micro_sample = '0;
        time_if.ready          = 1'b0;
        i_rst_n                = 1'b0;
        prev_reading  = '0;
        wrap_offset   = '0;
        last_day_seen = '0;
        steady        = 1'b0;
        hold_go       = 1'b0;
        hold_done     = 1'b0;
        rx_phase      = 0;
        rx_period     = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (edge_readings[k])
            queue_reading(edge_readings[k]);

        reading = edge_readings[edge_readings.size() - 1];
        for (int n = 0; n < RANDOM_READINGS; n++) begin
            if (n == 100)
                hold_go <= 1'b1;
            reading = next_reading(reading);
            queue_reading(reading);
        end

        // full rate, every step downward is a wrap
        steady <= 1'b1;
        for (int n = 0; n < ROLLOVER_READINGS; n++) begin
            if (reading > 32'd3000)
                reading = reading - $urandom_range(1, 3000);
            else
                reading = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            queue_reading(reading);
        end
        steady <= 1'b0;

        for (int n = 0; n < TAIL_READINGS; n++) begin
            reading = next_reading(reading);
            queue_reading(reading);
        end

        while (accepted_count < queued_count || elapsed_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d timer samples: %0d wraps, %0d day rollovers, %0d results checked",
                 accepted_count, wrap_count, rollover_count, checked_count);
        $display("included a %0d-cycle result hold-off and a full-rate stretch",
                 HOLD_CYCLES);
        if (miss_count == 0 && elapsed_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results missing", miss_count, elapsed_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
